// File: hw/rtl/kps_pkg.sv
// Shared types and constants for the matrix keypad scanner.
// No dependencies; imported by every module of the block.
package kps_pkg;

    localparam int SENSE_W   = 4;
    localparam int HOLDOFF_W = 16;
    localparam int TICK_W    = 32;
    localparam int KEY_IDX_W = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Register indexes, taken from paddr[2]
    localparam logic REG_HOLDOFF = 1'b0;
    localparam logic REG_LEVEL   = 1'b1;

    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd20;
    localparam logic                 LEVEL_RESET   = 1'b1;

    typedef struct packed {
        logic [HOLDOFF_W-1:0] holdoff;
        logic                 active_level;
    } cfg_t;

    typedef struct packed {
        logic                 key_valid;
        logic [KEY_IDX_W-1:0] key_row;
        logic [KEY_IDX_W-1:0] key_column;
        logic                 column_phase_next;
    } result_t;

endpackage

// File: hw/rtl/kps_line_scan.sv
// Priority encoder: lowest sense line at the active level.
// Depends on kps_pkg.
module kps_line_scan
    import kps_pkg::*;
#(
    parameter int COUNT = 4,
    parameter int IDX_W = 2
)
(
    input  logic [SENSE_W-1:0] lines,
    input  logic               active_level,
    output logic               found,
    output logic [IDX_W-1:0]   index
);

    always_comb
    begin
        found = 1'b0;
        index = '0;
        // scan from the top down so the lowest match wins
        for (int i = COUNT - 1; i >= 0; i--)
        begin
            if (lines[i] == active_level)
            begin
                found = 1'b1;
                index = IDX_W'(i);
            end
        end
    end

endmodule

// File: hw/rtl/kps_regs.sv
// APB configuration registers: press holdoff and active sense level.
// Depends on kps_pkg.
module kps_regs
    import kps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_HOLDOFF: cfg_next.holdoff      = pwdata[HOLDOFF_W-1:0];
                REG_LEVEL:   cfg_next.active_level = pwdata[0];
                default:     cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holdoff      <= HOLDOFF_RESET;
            cfg_reg.active_level <= LEVEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HOLDOFF: prdata = APB_DW'(cfg_reg.holdoff);
            REG_LEVEL:   prdata = APB_DW'(cfg_reg.active_level);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/kps_core.sv
// Scan state and latch update for one word: tick counter, phase,
// found row and column, holdoff check. Depends on kps_pkg, kps_line_scan.
module kps_core
    import kps_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               kind,
    input  logic [SENSE_W-1:0] sense_lines,
    input  cfg_t               cfg,
    output result_t            result
);

    localparam int ROW_SCAN  = (ROWS < SENSE_W) ? ROWS : SENSE_W;
    localparam int COL_SCAN  = (COLUMNS < SENSE_W) ? COLUMNS : SENSE_W;
    localparam int ROW_IDX_W = (ROW_SCAN > 1) ? $clog2(ROW_SCAN) : 1;
    localparam int COL_IDX_W = (COL_SCAN > 1) ? $clog2(COL_SCAN) : 1;

    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [TICK_W-1:0]    last_press_reg, last_press_next;
    logic                 column_phase_reg, column_phase_next;
    logic                 row_found_reg, row_found_next;
    logic [ROW_IDX_W-1:0] row_idx_reg, row_idx_next;
    logic                 col_found_reg, col_found_next;
    logic [COL_IDX_W-1:0] col_idx_reg, col_idx_next;
    logic                 latch_valid_reg, latch_valid_next;
    logic [ROW_IDX_W-1:0] latch_row_reg, latch_row_next;
    logic [COL_IDX_W-1:0] latch_col_reg, latch_col_next;

    logic                 scan_row_found;
    logic [ROW_IDX_W-1:0] scan_row_idx;
    logic                 scan_col_found;
    logic [COL_IDX_W-1:0] scan_col_idx;
    logic [TICK_W-1:0]    tick_inc;
    logic [TICK_W-1:0]    press_limit;
    logic                 tick_fire;

    kps_line_scan #(.COUNT(ROW_SCAN), .IDX_W(ROW_IDX_W)) u_row_scan
    (
        .lines        (sense_lines),
        .active_level (cfg.active_level),
        .found        (scan_row_found),
        .index        (scan_row_idx)
    );

    kps_line_scan #(.COUNT(COL_SCAN), .IDX_W(COL_IDX_W)) u_col_scan
    (
        .lines        (sense_lines),
        .active_level (cfg.active_level),
        .found        (scan_col_found),
        .index        (scan_col_idx)
    );

    assign tick_fire   = fire && (kind == KIND_TICK);
    assign tick_inc    = tick_count_reg + TICK_W'(1);
    assign press_limit = last_press_reg + TICK_W'(cfg.holdoff);

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        last_press_next   = last_press_reg;
        column_phase_next = column_phase_reg;
        row_found_next    = row_found_reg;
        row_idx_next      = row_idx_reg;
        col_found_next    = col_found_reg;
        col_idx_next      = col_idx_reg;
        latch_valid_next  = latch_valid_reg;
        latch_row_next    = latch_row_reg;
        latch_col_next    = latch_col_reg;

        if (tick_fire)
        begin
            tick_count_next   = tick_inc;
            column_phase_next = !column_phase_reg;
            if (column_phase_reg)
            begin
                col_found_next = scan_col_found;
                col_idx_next   = scan_col_idx;
            end
            else
            begin
                row_found_next = scan_row_found;
                row_idx_next   = scan_row_idx;
            end

            if (!row_found_next && !col_found_next)
            begin
                latch_valid_next = 1'b0;
                latch_row_next   = '0;
                latch_col_next   = '0;
            end
            else if (row_found_next && col_found_next && (tick_inc > press_limit))
            begin
                latch_valid_next = 1'b1;
                latch_row_next   = row_idx_next;
                latch_col_next   = col_idx_next;
                last_press_next  = tick_inc;
            end
        end
        else if (fire)
        begin
            // read: drop the latch after reporting it
            latch_valid_next = 1'b0;
            latch_row_next   = '0;
            latch_col_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            last_press_reg   <= '0;
            column_phase_reg <= 1'b1;
            row_found_reg    <= 1'b0;
            row_idx_reg      <= '0;
            col_found_reg    <= 1'b0;
            col_idx_reg      <= '0;
            latch_valid_reg  <= 1'b0;
            latch_row_reg    <= '0;
            latch_col_reg    <= '0;
        end
        else
        begin
            tick_count_reg   <= tick_count_next;
            last_press_reg   <= last_press_next;
            column_phase_reg <= column_phase_next;
            row_found_reg    <= row_found_next;
            row_idx_reg      <= row_idx_next;
            col_found_reg    <= col_found_next;
            col_idx_reg      <= col_idx_next;
            latch_valid_reg  <= latch_valid_next;
            latch_row_reg    <= latch_row_next;
            latch_col_reg    <= latch_col_next;
        end
    end

    // tick reports the updated latch, read reports it before clearing
    always_comb
    begin
        if (kind == KIND_READ)
        begin
            result.key_valid         = latch_valid_reg;
            result.key_row           = latch_valid_reg ? KEY_IDX_W'(latch_row_reg) : '0;
            result.key_column        = latch_valid_reg ? KEY_IDX_W'(latch_col_reg) : '0;
            result.column_phase_next = column_phase_reg;
        end
        else
        begin
            result.key_valid         = latch_valid_next;
            result.key_row           = latch_valid_next ? KEY_IDX_W'(latch_row_next) : '0;
            result.key_column        = latch_valid_next ? KEY_IDX_W'(latch_col_next) : '0;
            result.column_phase_next = column_phase_next;
        end
    end

endmodule

// File: hw/rtl/matrix_keypad_scanner.sv
// Top level of the matrix keypad scanner: input register, scan core,
// result register, APB registers. Depends on kps_pkg, kps_core, kps_regs.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per tick or read:
//   kind = 0 is a scan tick with the sense lines of the current phase,
//   kind = 1 reads and clears the latched key.
//   Output channel (out_valid / out_stall) returns one result word per
//   input word, in order: key_valid, key_row, key_column, column_phase_next.
//   An accepted word sits in the input register while the priority encode and
//   the 32-bit holdoff compare feed the result register, which loads the word
//   when it is empty or being taken and then raises out_valid. Throughput is
//   one word per cycle while the receiver does not stall; the core updates its
//   state in the cycle a word moves into the result register.
//   When the receiver stalls, the result register holds its word, the input
//   register fills, and in_stall rises only once both are occupied.
//   Reset clears the tick counter and press time, selects the column phase,
//   forgets found row and column, drops the latch, and sets the holdoff to
//   20 ticks and the active level to 1. Write the APB registers (holdoff at
//   0x0, active level at 0x4) only while no word is in flight.
module matrix_keypad_scanner
    import kps_pkg::*;
#(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [SENSE_W-1:0]   sense_lines,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 key_valid,
    output logic [KEY_IDX_W-1:0] key_row,
    output logic [KEY_IDX_W-1:0] key_column,
    output logic                 column_phase_next,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic               in_valid_reg, in_valid_next;
    logic               kind_reg;
    logic [SENSE_W-1:0] sense_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg;
    result_t            core_result;
    cfg_t               cfg;
    logic               advance;
    logic               in_take;
    logic               fire;

    kps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kps_core #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .kind        (kind_reg),
        .sense_lines (sense_reg),
        .cfg         (cfg),
        .result      (core_result)
    );

    // result register is free when empty or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            sense_reg <= sense_lines;
        end
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign key_valid         = result_reg.key_valid;
    assign key_row           = result_reg.key_row;
    assign key_column        = result_reg.key_column;
    assign column_phase_next = result_reg.column_phase_next;

endmodule

// File: tb/matrix_keypad_scanner_tb.sv
// Self-checking testbench for matrix_keypad_scanner: scan ticks and latch reads
// are checked against a scoreboard that predicts every result word.
// Depends on kps_pkg and the matrix_keypad_scanner RTL.
`timescale 1ns / 100ps

module matrix_keypad_scanner_tb;
    import kps_pkg::*;

    localparam int KP_ROWS    = 4;
    localparam int KP_COLUMNS = 4;
    localparam int LONG_HOLD  = 60;
    localparam int WDOG_LIMIT = 2000;

    class key_scoreboard;
        // configuration
        logic [HOLDOFF_W-1:0] holdoff;
        logic                 level;
        // scanner state
        logic [TICK_W-1:0]    ticks;
        logic [TICK_W-1:0]    press_tick;
        logic                 col_phase;
        logic                 row_hit;
        logic [2:0]           row_idx;
        logic                 col_hit;
        logic [2:0]           col_idx;
        logic                 latch_hit;
        logic [2:0]           latch_row;
        logic [2:0]           latch_col;

        result_t              expected_keys[$];
        int                   errors;
        int                   n_ticks;
        int                   n_reads;
        int                   n_latched;

        function new();
            holdoff    = HOLDOFF_RESET;
            level      = LEVEL_RESET;
            ticks      = '0;
            press_tick = '0;
            col_phase  = 1'b1;
            row_hit    = 1'b0;
            row_idx    = '0;
            col_hit    = 1'b0;
            col_idx    = '0;
            drop_latch();
            errors     = 0;
            n_ticks    = 0;
            n_reads    = 0;
            n_latched  = 0;
        endfunction

        function void write_reg(logic idx, logic [APB_DW-1:0] data);
            if (idx == REG_HOLDOFF)
                holdoff = data[HOLDOFF_W-1:0];
            else
                level = data[0];
        endfunction

        function void drop_latch();
            latch_hit = 1'b0;
            latch_row = '0;
            latch_col = '0;
        endfunction

        // lowest line at the active level, limited by the line count
        function void find_lowest(logic [SENSE_W-1:0] lines, int count,
                                  output logic hit, output logic [2:0] idx);
            hit = 1'b0;
            idx = '0;
            for (int i = 0; i < count && i < SENSE_W; i++) begin
                if (!hit && lines[i] == level) begin
                    hit = 1'b1;
                    idx = i[2:0];
                end
            end
        endfunction

        function result_t latch_word();
            result_t r;
            r.key_valid         = latch_hit;
            r.key_row           = latch_hit ? latch_row[KEY_IDX_W-1:0] : '0;
            r.key_column        = latch_hit ? latch_col[KEY_IDX_W-1:0] : '0;
            r.column_phase_next = col_phase;
            return r;
        endfunction

        function void note_word(logic k, logic [SENSE_W-1:0] lines);
            result_t           r;
            logic [TICK_W-1:0] limit;
            if (k == KIND_READ) begin
                n_reads++;
                r = latch_word();
                drop_latch();
            end else begin
                n_ticks++;
                ticks = ticks + 1'b1;
                if (col_phase)
                    find_lowest(lines, KP_COLUMNS, col_hit, col_idx);
                else
                    find_lowest(lines, KP_ROWS, row_hit, row_idx);
                if (!row_hit && !col_hit) begin
                    drop_latch();
                end else if (row_hit && col_hit) begin
                    limit = press_tick + TICK_W'(holdoff);
                    if (ticks > limit) begin
                        latch_hit  = 1'b1;
                        latch_row  = row_idx;
                        latch_col  = col_idx;
                        press_tick = ticks;
                    end
                end
                col_phase = ~col_phase;
                r = latch_word();
                if (r.key_valid)
                    n_latched++;
            end
            expected_keys.push_back(r);
        endfunction

        function void check_result(logic kv, logic [KEY_IDX_W-1:0] kr,
                                   logic [KEY_IDX_W-1:0] kc, logic cp);
            result_t e;
            if (expected_keys.size() == 0) begin
                $error("result word with nothing expected: valid %0d row %0d col %0d",
                       kv, kr, kc);
                errors++;
                return;
            end
            e = expected_keys.pop_front();
            if (kv !== e.key_valid) begin
                $error("key_valid: expected %0d, got %0d", e.key_valid, kv);
                errors++;
            end
            if (kr !== e.key_row) begin
                $error("key_row: expected %0d, got %0d", e.key_row, kr);
                errors++;
            end
            if (kc !== e.key_column) begin
                $error("key_column: expected %0d, got %0d", e.key_column, kc);
                errors++;
            end
            if (cp !== e.column_phase_next) begin
                $error("column_phase_next: expected %0d, got %0d",
                       e.column_phase_next, cp);
                errors++;
            end
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 kind        = KIND_TICK;
    logic [SENSE_W-1:0]   sense_lines = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 key_valid;
    logic [KEY_IDX_W-1:0] key_row;
    logic [KEY_IDX_W-1:0] key_column;
    logic                 column_phase_next;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [APB_AW-1:0]    paddr       = '0;
    logic [APB_DW-1:0]    pwdata      = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    key_scoreboard sb = new();
    bit            idling_on     = 1'b1;
    bit            long_hold_req = 1'b0;
    int            words_sent    = 0;
    int            idle_cycles   = 0;

    matrix_keypad_scanner #(
        .ROWS    (KP_ROWS),
        .COLUMNS (KP_COLUMNS)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .sense_lines       (sense_lines),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .key_valid         (key_valid),
        .key_row           (key_row),
        .key_column        (key_column),
        .column_phase_next (column_phase_next),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #10 clk = ~clk;

    // result checking and the progress watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(key_valid, key_row, key_column, column_phase_next);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WDOG_LIMIT);
        $display("Timeout: no word moved for %0d cycles", WDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side: random stall bursts, or one long hold-off on request
    initial
    begin : receiver
        int n;
        forever
        begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic k, logic [SENSE_W-1:0] lines);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        kind        <= k;
        sense_lines <= lines;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(k, lines);
        words_sent++;
    endtask

    task automatic send_tick(logic [SENSE_W-1:0] lines);
        send_word(KIND_TICK, lines);
    endtask

    task automatic send_read();
        send_word(KIND_READ, SENSE_W'($urandom));
    endtask

    // hold off new words until every result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reconfigure(logic [HOLDOFF_W-1:0] hold, logic lvl);
        drain();
        repeat (4) @(posedge clk);
        apb_write(REG_HOLDOFF, APB_DW'(hold));
        apb_write(REG_LEVEL, APB_DW'(lvl));
    endtask

    // lines with line k at the active level and every lower line inactive
    function automatic logic [SENSE_W-1:0] key_lines(int k, logic lvl);
        logic [SENSE_W-1:0] v;
        v = SENSE_W'($urandom);
        for (int i = 0; i < k; i++)
            v[i] = ~lvl;
        v[k] = lvl;
        return v;
    endfunction

    // hold one key for a while, then release it; some ticks bounce
    task automatic press_sequence();
        int   r;
        int   c;
        int   n;
        logic lvl;
        r   = $urandom_range(0, KP_ROWS - 1);
        c   = $urandom_range(0, KP_COLUMNS - 1);
        n   = $urandom_range(2, 30);
        lvl = sb.level;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_tick(SENSE_W'($urandom));
            else
                send_tick(sb.col_phase ? key_lines(c, lvl) : key_lines(r, lvl));
            if ($urandom_range(0, 9) == 0)
                send_read();
        end
        if ($urandom_range(0, 1) == 0)
            send_read();
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_tick({SENSE_W{~lvl}});
    endtask

    task automatic run_random(int count, bit gaps_allowed);
        int stop_at;
        int next_toggle;
        stop_at     = words_sent + count;
        next_toggle = words_sent;
        while (words_sent < stop_at) begin
            if (words_sent >= next_toggle) begin
                idling_on   = gaps_allowed && ($urandom_range(0, 3) != 0);
                next_toggle = words_sent + 40;
            end
            case ($urandom_range(0, 9))
                0:       repeat ($urandom_range(1, 6)) send_tick(SENSE_W'($urandom));
                1:       send_read();
                default: press_sequence();
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: both lines found, but the holdoff blocks the latch
        send_read();
        send_tick(4'b0010);
        send_tick(4'b0100);
        send_tick(4'b0000);
        send_read();

        reconfigure(16'd0, 1'b1);
        send_tick(4'b0000);
        send_tick(4'b0001);
        send_tick(4'b0001);
        send_tick(4'b0000);   // column lost, row kept: latch stays
        send_tick(4'b0000);   // nothing found: latch drops
        send_tick(4'b1111);
        send_tick(4'b0110);
        send_read();
        send_read();          // second read finds the latch empty
        send_tick(4'b1000);
        send_tick(4'b1000);

        reconfigure(16'd0, 1'b0);
        send_tick(4'b1110);
        send_tick(4'b0111);
        send_read();
        send_tick(4'b1111);
        send_tick(4'b0000);
        send_read();

        run_random(120, 1'b1);

        reconfigure(16'd3, 1'b1);
        run_random(60, 1'b1);
        // fill the block against a long output hold-off
        idling_on     = 1'b0;
        long_hold_req = 1'b1;
        repeat (12) send_tick(SENSE_W'($urandom));
        drain();
        run_random(60, 1'b1);

        reconfigure(16'hFFFF, 1'b1);
        run_random(60, 1'b1);

        reconfigure(16'd20, 1'b0);
        run_random(120, 1'b1);

        reconfigure(16'd1, 1'b1);
        run_random(180, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d words: %0d scan ticks, %0d latch reads, %0d ticks with a key held",
                 words_sent, sb.n_ticks, sb.n_reads, sb.n_latched);
        $display("Holdoff 0 to 65535, both active levels, long output hold-off and drain pause");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/kps_pkg.sv
hw/rtl/kps_line_scan.sv
hw/rtl/kps_regs.sv
hw/rtl/kps_core.sv
hw/rtl/matrix_keypad_scanner.sv
tb/matrix_keypad_scanner_tb.sv
